// File: src/mtr_pkg.sv
// ----------------------------------------------------------------------------
// mtr_pkg
// Shared types and constants of the MIDI tempo rescaler.
// ----------------------------------------------------------------------------
`default_nettype none

package mtr_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned TEMPO_W   = 24;
	localparam int unsigned RATE_W    = 24;
	localparam int unsigned FRAC_W    = 16;
	localparam int unsigned PRODUCT_W = TEMPO_W + RATE_W;
	localparam int unsigned LEFT_W    = 32;

	localparam logic [RATE_W-1:0]  RATE_RESET  = 24'h010000;
	localparam logic [TEMPO_W-1:0] TEMPO_MAX   = 24'hFFFFFF;
	localparam logic [BYTE_W-1:0]  META_STATUS = 8'hFF;
	localparam logic [BYTE_W-1:0]  TEMPO_TYPE  = 8'h51;
	localparam logic [BYTE_W-1:0]  TEMPO_LEN   = 8'h03;
	localparam logic [3:0]         SYSTEM_HI   = 4'hF;
	localparam logic [3:0]         PROGRAM_HI  = 4'hC;
	localparam logic [3:0]         PRESSURE_HI = 4'hD;

	typedef struct packed {
		logic                is_tempo;
		logic [BYTE_W-1:0]   data;
		logic                stopped;
		logic [TEMPO_W-1:0]  tempo;
	} item_t;

	typedef struct packed {
		logic                is_tempo;
		logic [BYTE_W-1:0]   data;
		logic                stopped;
		logic [PRODUCT_W-1:0] product;
	} scaled_t;

	function automatic logic [1:0] data_count(input logic [BYTE_W-1:0] status);
		logic [3:0] hi;
		hi = status[7:4];
		data_count = (hi == PROGRAM_HI || hi == PRESSURE_HI) ? 2'd1 : 2'd2;
	endfunction

endpackage

`default_nettype wire

// File: src/mtr_parser.sv
// ----------------------------------------------------------------------------
// mtr_parser
// Walks the track grammar one byte per transaction and registers one result
// descriptor per byte that causes output.
// ----------------------------------------------------------------------------
`default_nettype none

module mtr_parser
	import mtr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [BYTE_W-1:0] in_byte,
	output logic                   valid_s1,
	output item_t                  item_s1,
	input  wire logic              s1_stall
);

	typedef enum logic [2:0] {
		PH_DELTA,
		PH_STATUS,
		PH_DATA,
		PH_META_TYPE,
		PH_META_LEN,
		PH_META_SKIP,
		PH_TEMPO,
		PH_STOPPED
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [BYTE_W-1:0]   status_q, status_d;
	logic [LEFT_W-1:0]   left_q, left_d, left_dec, left_len;
	logic                tempo_meta_q, tempo_meta_d;
	logic [TEMPO_W-1:0]  hold_q, hold_d;
	logic [1:0]          count_q, count_d;
	logic [1:0]          run_left;
	logic                has_result;
	item_t               result;
	logic                accept;

	assign in_stall = valid_s1 && s1_stall;
	assign accept   = in_valid && !in_stall;
	assign left_dec = (left_q != '0) ? left_q - LEFT_W'(1) : left_q;
	assign left_len = {left_q[LEFT_W-8:0], in_byte[6:0]};
	assign run_left = data_count(status_q) - 2'd1;

	always_comb begin
		phase_d         = phase_q;
		status_d        = status_q;
		left_d          = left_q;
		tempo_meta_d    = tempo_meta_q;
		hold_d          = hold_q;
		count_d         = count_q;
		has_result      = 1'b1;
		result.is_tempo = 1'b0;
		result.data     = in_byte;
		result.stopped  = 1'b0;
		result.tempo    = hold_q;
		unique case (phase_q)
			PH_DELTA: begin
				if (!in_byte[7])
					phase_d = PH_STATUS;
			end
			PH_STATUS: begin
				if (in_byte == META_STATUS) begin
					phase_d = PH_META_TYPE;
				end else if (in_byte[7:4] == SYSTEM_HI) begin
					phase_d        = PH_STOPPED;
					result.stopped = 1'b1;
				end else if (in_byte[7]) begin
					status_d = in_byte;
					left_d   = {{(LEFT_W-2){1'b0}}, data_count(in_byte)};
					phase_d  = PH_DATA;
				end else begin
					left_d  = {{(LEFT_W-2){1'b0}}, run_left};
					phase_d = (run_left != 2'd0) ? PH_DATA : PH_DELTA;
				end
			end
			PH_DATA, PH_META_SKIP: begin
				left_d = left_dec;
				if (left_dec == '0)
					phase_d = PH_DELTA;
			end
			PH_META_TYPE: begin
				tempo_meta_d = (in_byte == TEMPO_TYPE);
				left_d       = '0;
				phase_d      = PH_META_LEN;
			end
			PH_META_LEN: begin
				tempo_meta_d = 1'b0;
				if (tempo_meta_q && in_byte == TEMPO_LEN) begin
					hold_d  = '0;
					count_d = 2'd0;
					phase_d = PH_TEMPO;
				end else begin
					left_d = left_len;
					if (!in_byte[7])
						phase_d = (left_len != '0) ? PH_META_SKIP : PH_DELTA;
				end
			end
			PH_TEMPO: begin
				hold_d = {hold_q[TEMPO_W-9:0], in_byte};
				if (count_q == 2'd2) begin
					result.is_tempo = 1'b1;
					result.tempo    = {hold_q[TEMPO_W-9:0], in_byte};
					count_d         = 2'd0;
					phase_d         = PH_DELTA;
				end else begin
					count_d    = count_q + 2'd1;
					has_result = 1'b0;
				end
			end
			PH_STOPPED: begin
				result.stopped = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_DELTA;
			status_q     <= '0;
			left_q       <= '0;
			tempo_meta_q <= 1'b0;
			hold_q       <= '0;
			count_q      <= 2'd0;
			valid_s1     <= 1'b0;
			item_s1      <= '0;
		end else begin
			if (accept) begin
				phase_q      <= phase_d;
				status_q     <= status_d;
				left_q       <= left_d;
				tempo_meta_q <= tempo_meta_d;
				hold_q       <= hold_d;
				count_q      <= count_d;
				valid_s1     <= has_result;
				item_s1      <= result;
			end else if (!s1_stall) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Once a system status has stopped parsing, only a reset restarts it.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_STOPPED |=> phase_q == PH_STOPPED)
		else $error("parser left the stopped phase");

	// A tempo value holds at most two bytes before it is released.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_TEMPO |-> count_q == 2'd0 || $past(phase_q) == PH_TEMPO)
		else $error("stale tempo byte count outside a tempo value");

endmodule

`default_nettype wire

// File: src/mtr_scaler.sv
// ----------------------------------------------------------------------------
// mtr_scaler
// Multiplies a held tempo by the Q8.16 rate and registers the full product.
// ----------------------------------------------------------------------------
`default_nettype none

module mtr_scaler
	import mtr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [RATE_W-1:0] rate_scale_q,
	input  wire logic              valid_s1,
	input  wire item_t             item_s1,
	output logic                   s1_stall,
	output logic                   valid_s2,
	output scaled_t                item_s2,
	input  wire logic              s2_stall
);

	assign s1_stall = valid_s2 && s2_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!s1_stall) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!s1_stall && valid_s1) begin
			item_s2.is_tempo <= item_s1.is_tempo;
			item_s2.data     <= item_s1.data;
			item_s2.stopped  <= item_s1.stopped;
			item_s2.product  <= PRODUCT_W'(item_s1.tempo) * PRODUCT_W'(rate_scale_q);
		end
	end

endmodule

`default_nettype wire

// File: src/mtr_emitter.sv
// ----------------------------------------------------------------------------
// mtr_emitter
// Output register: passes a byte through, or saturates a scaled tempo and
// sends its three bytes most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

module mtr_emitter
	import mtr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              valid_s2,
	input  wire scaled_t           item_s2,
	output logic                   s2_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [BYTE_W-1:0]      out_byte,
	output logic                   last_of_run,
	output logic                   tempo_changed,
	output logic                   parse_stopped
);

	logic [1:0]            rem_q;
	logic [2*BYTE_W-1:0]   spare_q;
	logic [TEMPO_W-1:0]    scaled;
	logic                  ready;
	logic                  take;
	logic                  shift;

	assign scaled = (item_s2.product[PRODUCT_W-1:FRAC_W+TEMPO_W] != '0) ? TEMPO_MAX :
		item_s2.product[FRAC_W+TEMPO_W-1:FRAC_W];
	assign ready    = !out_valid || (!out_stall && rem_q == 2'd0);
	assign s2_stall = !ready;
	assign take     = valid_s2 && ready;
	assign shift    = out_valid && !out_stall && rem_q != 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			rem_q     <= 2'd0;
		end else begin
			if (take) begin
				out_valid <= 1'b1;
				rem_q     <= item_s2.is_tempo ? 2'd2 : 2'd0;
			end else if (shift) begin
				rem_q <= rem_q - 2'd1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (item_s2.is_tempo) begin
				out_byte      <= scaled[TEMPO_W-1:2*BYTE_W];
				spare_q       <= scaled[2*BYTE_W-1:0];
				last_of_run   <= 1'b0;
				tempo_changed <= 1'b1;
				parse_stopped <= 1'b0;
			end else begin
				out_byte      <= item_s2.data;
				last_of_run   <= 1'b1;
				tempo_changed <= 1'b0;
				parse_stopped <= item_s2.stopped;
			end
		end else if (shift) begin
			out_byte    <= spare_q[2*BYTE_W-1:BYTE_W];
			spare_q     <= {spare_q[BYTE_W-1:0], {BYTE_W{1'b0}}};
			last_of_run <= (rem_q == 2'd1);
		end
	end

	// Bytes still waiting behind the output belong to a tempo value.
	assert property (@(posedge clk) disable iff (!arst_n)
		rem_q != 2'd0 |-> out_valid && tempo_changed && !last_of_run)
		else $error("pending bytes outside a tempo value");

	// A tempo value is sent as one unbroken run of three bytes.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && tempo_changed && !last_of_run
		|=> out_valid && tempo_changed)
		else $error("tempo run broken");

endmodule

`default_nettype wire

// File: src/midi_tempo_rescaler.sv
// ----------------------------------------------------------------------------
// midi_tempo_rescaler
// Rescales the tempo meta events of a MIDI track byte stream.
// ----------------------------------------------------------------------------
// The block takes one stream byte per cycle while in_stall is low and passes
// every byte through unchanged, except the three value bytes of a tempo meta
// event (FF 51 03), which are replaced by the tempo times rate_scale (unsigned
// Q8.16), truncated and saturated at 0xFFFFFF. The first two tempo bytes give
// no output and the third gives all three rescaled bytes as one unbroken run;
// the output register is busy while it sends the last two, so a tempo event
// can stall the input. A result passes the parser, multiplier and output
// register, each one register stage, the first loaded at the edge that
// accepts its byte. A stall on the output reaches in_stall in the same cycle.
// A system status F0 to FE stops parsing until reset; later bytes pass with
// parse_stopped set. Write rate_scale only while no transaction is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_tempo_rescaler
	import mtr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [RATE_W-1:0] rate_scale,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [BYTE_W-1:0] in_byte,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [BYTE_W-1:0]      out_byte,
	output logic                   last_of_run,
	output logic                   tempo_changed,
	output logic                   parse_stopped
);

	logic [RATE_W-1:0] rate_scale_q;
	logic              valid_s1;
	item_t             item_s1;
	logic              s1_stall;
	logic              valid_s2;
	scaled_t           item_s2;
	logic              s2_stall;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_scale_q <= RATE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			rate_scale_q <= rate_scale;
		end
	end

	mtr_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.s1_stall (s1_stall)
	);

	mtr_scaler u_scaler (
		.clk          (clk),
		.arst_n       (arst_n),
		.rate_scale_q (rate_scale_q),
		.valid_s1     (valid_s1),
		.item_s1      (item_s1),
		.s1_stall     (s1_stall),
		.valid_s2     (valid_s2),
		.item_s2      (item_s2),
		.s2_stall     (s2_stall)
	);

	mtr_emitter u_emitter (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s2      (valid_s2),
		.item_s2       (item_s2),
		.s2_stall      (s2_stall),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.last_of_run   (last_of_run),
		.tempo_changed (tempo_changed),
		.parse_stopped (parse_stopped)
	);

endmodule

`default_nettype wire
